FILE: design/lmsd_pkg.sv
// ----------------------------------------------------------------------------
// lmsd_pkg
// Shared types, constants and helpers for the 8x8 LED matrix scan driver.
// ----------------------------------------------------------------------------
package lmsd_pkg;

    localparam int LMS_ROWS      = 8;
    localparam int LMS_ROW_W     = $clog2(LMS_ROWS);
    localparam int LMS_COL_W     = 8;

    localparam int LMS_S_DATA_W  = 16;
    localparam int LMS_M_DATA_W  = 24;
    localparam int LMS_CFG_IDX_W = 3;
    localparam int LMS_CFG_DAT_W = 1;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_SHOW  = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [LMS_CFG_IDX_W-1:0] {
        CFG_TRANSPOSE_ENABLE    = 3'd0,
        CFG_ROW_ORDER_REVERSED  = 3'd1,
        CFG_COLUMN_ORDER_KEPT   = 3'd2,
        CFG_COLUMNS_ACTIVE_HIGH = 3'd3,
        CFG_ROWS_ACTIVE_LOW     = 3'd4
    } cfg_index_t;

    typedef logic [LMS_COL_W-1:0] row_byte_t;
    typedef row_byte_t [LMS_ROWS-1:0] frame_t;

    function automatic row_byte_t bit_rev8(input row_byte_t v);
        row_byte_t t0;
        row_byte_t t1;
        row_byte_t t2;
        t0 = ((v  & 8'hF0) >> 4) | ((v  & 8'h0F) << 4);
        t1 = ((t0 & 8'hCC) >> 2) | ((t0 & 8'h33) << 2);
        t2 = ((t1 & 8'hAA) >> 1) | ((t1 & 8'h55) << 1);
        return t2;
    endfunction

endpackage

FILE: design/led_matrix_scan_driver_8x8_unit.sv
// ----------------------------------------------------------------------------
// led_matrix_scan_driver_8x8_unit
// Row-multiplexed scan driver for an 8x8 LED matrix with staged frame updates.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries requests: write a staging row, show the staged frame,
//   advance the scan by one row (tick) or clear the framebuffer.
//   m_* channel returns one result per request: row pin levels, column pin
//   levels and the active scan row, taken after the request is applied.
//   cfg_* is a plain write port for the orientation and polarity registers;
//   write it only while no request is in flight.
// Timing:
//   a request is registered in the input register on accept, and its result
//   is registered in the result register, which raises m_tvalid, when the
//   request advances. One request per cycle is sustained while m_tready
//   stays high; the path from input register to result register is a single
//   pass of wiring (transpose, bit reversal) and one row select.
// Reset:
//   framebuffer cleared, scan at row 0 and not started, no result valid,
//   polarity registers at columns active high and rows active low.
// Stall:
//   when m_tready is low the result is held; one more request is buffered in
//   the input register, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module led_matrix_scan_driver_8x8_unit
    import lmsd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    // func [1:0], row_index [4:2], row_bits [12:5], zero [15:13]
    input  logic [LMS_S_DATA_W-1:0]  s_tdata,

    output logic                     m_tvalid,
    input  logic                     m_tready,
    // row_drive [7:0], column_drive [15:8], active_row [18:16], zero [23:19]
    output logic [LMS_M_DATA_W-1:0]  m_tdata,

    input  logic                     cfg_wr_en,
    input  logic [LMS_CFG_IDX_W-1:0] cfg_index,
    input  logic [LMS_CFG_DAT_W-1:0] cfg_wr_data
);

    // configuration
    logic transpose_enable_reg;
    logic row_order_reversed_reg;
    logic column_order_kept_reg;
    logic columns_active_high_reg;
    logic rows_active_low_reg;

    // input register
    logic                 in_valid_reg;
    func_t                in_func_reg;
    logic [LMS_ROW_W-1:0] in_row_index_reg;
    row_byte_t            in_row_bits_reg;

    // block state
    frame_t               staging_reg;
    frame_t               staging_next;
    frame_t               framebuffer_reg;
    frame_t               framebuffer_next;
    logic [LMS_ROW_W-1:0] scan_row_reg;
    logic [LMS_ROW_W-1:0] scan_row_next;
    logic                 scan_started_reg;
    logic                 scan_started_next;
    row_byte_t            column_latch_reg;
    row_byte_t            column_latch_next;

    // result register
    logic                    out_valid_reg;
    logic [LMS_M_DATA_W-1:0] out_data_reg;
    logic [LMS_M_DATA_W-1:0] out_data_next;

    logic      advance;
    frame_t    work;
    frame_t    shown;
    row_byte_t row_sel;
    row_byte_t row_pins;
    row_byte_t lit;
    row_byte_t col_pins;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transpose_enable_reg    <= 1'b0;
            row_order_reversed_reg  <= 1'b0;
            column_order_kept_reg   <= 1'b0;
            columns_active_high_reg <= 1'b1;
            rows_active_low_reg     <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TRANSPOSE_ENABLE:    transpose_enable_reg    <= cfg_wr_data[0];
                CFG_ROW_ORDER_REVERSED:  row_order_reversed_reg  <= cfg_wr_data[0];
                CFG_COLUMN_ORDER_KEPT:   column_order_kept_reg   <= cfg_wr_data[0];
                CFG_COLUMNS_ACTIVE_HIGH: columns_active_high_reg <= cfg_wr_data[0];
                CFG_ROWS_ACTIVE_LOW:     rows_active_low_reg     <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // show path: transpose, row order, column order
    always_comb begin
        for (int r = 0; r < LMS_ROWS; r++) begin
            for (int c = 0; c < LMS_ROWS; c++) begin
                work[r][LMS_ROWS-1-c] = transpose_enable_reg ? staging_reg[c][LMS_ROWS-1-r]
                                                             : staging_reg[r][LMS_ROWS-1-c];
            end
        end
        for (int r = 0; r < LMS_ROWS; r++) begin
            row_byte_t src;
            src = row_order_reversed_reg ? work[LMS_ROWS-1-r] : work[r];
            shown[r] = column_order_kept_reg ? src : bit_rev8(src);
        end
    end

    always_comb begin
        staging_next      = staging_reg;
        framebuffer_next  = framebuffer_reg;
        scan_row_next     = scan_row_reg;
        scan_started_next = scan_started_reg;
        column_latch_next = column_latch_reg;
        if (advance) begin
            unique case (in_func_reg)
                FUNC_WRITE: staging_next[in_row_index_reg] = in_row_bits_reg;
                FUNC_SHOW:  framebuffer_next = shown;
                FUNC_TICK: begin
                    // 3-bit counter wraps modulo the row count
                    scan_row_next     = scan_row_reg + 1'b1;
                    scan_started_next = 1'b1;
                    column_latch_next = framebuffer_reg[scan_row_next];
                end
                FUNC_CLEAR: framebuffer_next = '0;
                default: ;
            endcase
        end
    end

    // pin levels from the updated scan state
    always_comb begin
        row_sel       = scan_started_next ? row_byte_t'(1) << scan_row_next : '0;
        row_pins      = rows_active_low_reg ? ~row_sel : row_sel;
        lit           = scan_started_next ? column_latch_next : '0;
        col_pins      = columns_active_high_reg ? lit : ~lit;
        out_data_next = {{(LMS_M_DATA_W-LMS_ROW_W-2*LMS_COL_W){1'b0}},
                         scan_row_next, col_pins, row_pins};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            framebuffer_reg  <= '0;
            scan_row_reg     <= '0;
            scan_started_reg <= 1'b0;
            column_latch_reg <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            framebuffer_reg  <= framebuffer_next;
            scan_row_reg     <= scan_row_next;
            scan_started_reg <= scan_started_next;
            column_latch_reg <= column_latch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg      <= func_t'(s_tdata[1:0]);
            in_row_index_reg <= s_tdata[4:2];
            in_row_bits_reg  <= s_tdata[12:5];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
        staging_reg <= staging_next;
    end

endmodule
